>>> hw/rtl/pps_pkg.sv
// shared types, constants and helpers for the per-process shadow return stack
package pps_pkg;

  localparam int PROCS  = 8;
  localparam int DEPTH  = 256;
  localparam int SLOT_W = (PROCS > 1) ? $clog2(PROCS) : 1;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(PROCS * DEPTH);
  localparam int OUT_FILL_W = 9;

  typedef enum logic [1:0] {
    KIND_ENABLE  = 2'd0,
    KIND_DISABLE = 2'd1,
    KIND_PUSH    = 2'd2,
    KIND_CHECK   = 2'd3
  } kind_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] cr3;
    logic [63:0] return_addr;
    logic [63:0] rip;
  } cmd_t;

  typedef struct packed {
    logic                  monitored;
    logic                  enable_ok;
    logic                  rop_detected;
    logic [63:0]           expected_addr;
    logic [63:0]           alert_rip;
    logic [63:0]           alert_key;
    logic [63:0]           alert_actual_addr;
    logic [31:0]           mismatch_total;
    logic [OUT_FILL_W-1:0] stack_fill;
  } res_t;

  // flat store address of one ring entry
  function automatic logic [ADDR_W-1:0] store_addr(logic [SLOT_W-1:0] slot,
                                                   logic [PTR_W-1:0] ptr);
    store_addr = ADDR_W'(slot) * ADDR_W'(DEPTH) + ADDR_W'(ptr);
  endfunction

  // ring position below ptr, wrapping at the bottom
  function automatic logic [PTR_W-1:0] ptr_dec(logic [PTR_W-1:0] ptr);
    ptr_dec = (ptr == '0) ? PTR_W'(DEPTH - 1) : ptr - PTR_W'(1);
  endfunction

  // ring position above ptr, wrapping at the top
  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] ptr);
    ptr_inc = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

endpackage

>>> hw/rtl/per_process_shadow_return_stack_top.sv
// per-process return-address shadow stack: key table plus one ring store
// accept moves the state into ST_EXEC, and from there the result register strobes
// one item at a time (busy holds off the next); the accept matches the key and reads
//   the ring store, then ST_EXEC does the read-modify-write of slot state and store
// reset clears every slot at once (no clearing pass); the ring store is not cleared
// the result strobe is high for one cycle only, since the receiver cannot stall
module per_process_shadow_return_stack_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  pps_pkg::cmd_t cmd,
  output logic         done,
  output pps_pkg::res_t result
);
  import pps_pkg::*;

  // slot table, small enough for flops; keys are compared in parallel
  logic                 slot_active [PROCS];
  logic [63:0]          slot_key    [PROCS];
  logic [PTR_W-1:0]     slot_top    [PROCS];
  logic [FILL_W-1:0]    slot_fill   [PROCS];
  logic [31:0]          slot_mis    [PROCS];

  // ring store, one synchronous memory with registered read
  logic [63:0]          ret_mem [PROCS*DEPTH];
  logic [63:0]          rd_data;
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;

  state_t               state, state_next;
  logic                 accept;

  // item captured at the start transfer
  cmd_t                 cmd_q;
  logic                 hit_q;
  logic                 free_q;
  logic [SLOT_W-1:0]    slot_q;

  // key match and free slot search on the incoming item
  logic                 hit;
  logic [SLOT_W-1:0]    hit_slot;
  logic                 free_found;
  logic [SLOT_W-1:0]    free_slot;

  // ST_EXEC results
  res_t                 result_next;
  logic                 done_next;
  logic [PTR_W-1:0]     cur_top;
  logic [FILL_W-1:0]    cur_fill;
  logic [31:0]          cur_mis;
  logic [PTR_W-1:0]     pop_ptr;
  logic                 do_claim;
  logic                 do_free;
  logic                 do_push;
  logic                 do_pop;
  logic                 mismatch;
  logic [PTR_W-1:0]     top_next;
  logic [FILL_W-1:0]    fill_next;
  logic [31:0]          mis_next;

  assign accept = start && !busy;

  // lowest-numbered match wins, so scan from the top down
  always_comb begin
    hit        = 1'b0;
    hit_slot   = '0;
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = PROCS - 1; i >= 0; i--) begin
      if (slot_active[i] && slot_key[i] == cmd.cr3) begin
        hit      = 1'b1;
        hit_slot = SLOT_W'(i);
      end
      if (!slot_active[i]) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(i);
      end
    end
  end

  // pop reads the entry just below top, issued in the accept cycle
  assign rd_en   = accept;
  assign rd_addr = store_addr(hit_slot, ptr_dec(slot_top[hit_slot]));

  // state machine: next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_EXEC;
      end
      ST_EXEC: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // state machine: outputs
  always_comb begin
    busy      = 1'b0;
    done_next = 1'b0;
    case (state)
      ST_IDLE: busy = 1'b0;
      ST_EXEC: begin
        busy      = 1'b1;
        done_next = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // capture the item with its lookup; on a miss the slot is the free one
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= cmd;
      hit_q  <= hit;
      free_q <= free_found;
      slot_q <= hit ? hit_slot : free_slot;
    end
  end

  // read-modify-write of the selected slot
  always_comb begin
    cur_top  = slot_top[slot_q];
    cur_fill = slot_fill[slot_q];
    cur_mis  = slot_mis[slot_q];
    pop_ptr  = ptr_dec(cur_top);

    do_claim = (cmd_q.kind == KIND_ENABLE) && !hit_q && free_q;
    do_free  = (cmd_q.kind == KIND_DISABLE) && hit_q;
    do_push  = (cmd_q.kind == KIND_PUSH) && hit_q;
    do_pop   = (cmd_q.kind == KIND_CHECK) && hit_q && (cur_fill != '0);
    mismatch = do_pop && (rd_data != cmd_q.return_addr);

    top_next  = cur_top;
    fill_next = cur_fill;
    mis_next  = cur_mis;
    if (do_claim) begin
      top_next  = '0;
      fill_next = '0;
      mis_next  = '0;
    end else if (do_push) begin
      top_next = ptr_inc(cur_top);
      // a full ring overwrites its oldest entry and the fill holds
      if (cur_fill != FILL_W'(DEPTH)) fill_next = cur_fill + FILL_W'(1);
    end else if (do_pop) begin
      top_next  = pop_ptr;
      fill_next = cur_fill - FILL_W'(1);
      if (mismatch && cur_mis != '1) mis_next = cur_mis + 32'd1;
    end

    result_next                   = '0;
    result_next.monitored         = hit_q;
    result_next.enable_ok         = (cmd_q.kind == KIND_ENABLE) && (hit_q || free_q);
    result_next.rop_detected      = mismatch;
    result_next.expected_addr     = do_pop ? rd_data : 64'd0;
    if (mismatch) begin
      result_next.alert_rip         = cmd_q.rip;
      result_next.alert_key         = cmd_q.cr3;
      result_next.alert_actual_addr = cmd_q.return_addr;
    end
    // a slot that is active after this step reports its counters
    if ((hit_q && cmd_q.kind != KIND_DISABLE) || do_claim) begin
      result_next.mismatch_total = mis_next;
      result_next.stack_fill     = OUT_FILL_W'(fill_next);
    end
  end

  assign wr_en   = busy && do_push;
  assign wr_addr = store_addr(slot_q, cur_top);

  always_ff @(posedge clk) begin
    if (wr_en) ret_mem[wr_addr] <= cmd_q.return_addr;
    if (rd_en) rd_data <= ret_mem[rd_addr];
  end

  // slot table update at the end of ST_EXEC
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PROCS; i++) begin
        slot_active[i] <= 1'b0;
        slot_top[i]    <= '0;
        slot_fill[i]   <= '0;
        slot_mis[i]    <= '0;
      end
    end else if (busy) begin
      if (do_claim) begin
        slot_active[slot_q] <= 1'b1;
      end else if (do_free) begin
        slot_active[slot_q] <= 1'b0;
      end
      slot_top[slot_q]  <= top_next;
      slot_fill[slot_q] <= fill_next;
      slot_mis[slot_q]  <= mis_next;
    end
  end

  // keys hold no reset; they are only compared while the slot is active
  always_ff @(posedge clk) begin
    if (busy && do_claim) slot_key[slot_q] <= cmd_q.cr3;
  end

  // result register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (done_next) result <= result_next;
  end

endmodule

>>> hw/rtl/pps_checker.sv
// port-level checks for the shadow return stack, bound to the top level
module pps_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input pps_pkg::cmd_t cmd,
  input logic          done,
  input pps_pkg::res_t result
);
  import pps_pkg::*;

  // a start transfer makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("start transfer not followed by busy");

  // every busy cycle ends in a result strobe, and busy drops again
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> (done && !busy))
    else $error("busy cycle not followed by result strobe");

  // no detection on a key that was not monitored
  a_detect_monitored: assert property (@(posedge clk) disable iff (rst)
    (done && result.rop_detected) |-> result.monitored)
    else $error("detection on an unmonitored key");

  // a detection reports an actual address that differs from the popped one
  a_detect_differs: assert property (@(posedge clk) disable iff (rst)
    (done && result.rop_detected) |-> (result.alert_actual_addr != result.expected_addr))
    else $error("detection with matching addresses");

  // enable success is reported only for enable items
  a_enable_only: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.kind != KIND_ENABLE) |=> ##1 !result.enable_ok)
    else $error("enable_ok on a non-enable item");

endmodule

bind per_process_shadow_return_stack_top pps_checker u_pps_checker (.*);

>>> verif/pps_return_checker.sv
`timescale 1ns / 1ps
// scoreboard for the shadow return stack: predicts each command and checks each result
module pps_return_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  pps_pkg::cmd_t cmd,
  input  logic          done,
  input  pps_pkg::res_t result,
  output int            errors,
  output int            pending,
  output int            compared,
  output int            detections,
  output int            refused
);
  import pps_pkg::*;

  // predicted slot table and ring store
  bit          slot_on     [PROCS];
  logic [63:0] slot_cr3    [PROCS];
  int          ring_top    [PROCS];
  int          ring_fill   [PROCS];
  logic [31:0] slot_misses [PROCS];
  logic [63:0] ring_mem    [PROCS*DEPTH];

  res_t awaited[$];
  res_t oldest;
  res_t fresh;

  function automatic res_t shadow_step(cmd_t c);
    res_t        r;
    int          s;
    int          p;
    logic [63:0] popped;
    r = '0;
    s = -1;
    // lowest matching active slot wins
    for (int i = PROCS - 1; i >= 0; i--) begin
      if (slot_on[i] && slot_cr3[i] == c.cr3) s = i;
    end
    r.monitored = (s >= 0);
    case (c.kind)
      KIND_ENABLE: begin
        if (s >= 0) begin
          r.enable_ok = 1'b1;
        end else begin
          for (int i = PROCS - 1; i >= 0; i--) begin
            if (!slot_on[i]) s = i;
          end
          if (s >= 0) begin
            slot_on[s]     = 1'b1;
            slot_cr3[s]    = c.cr3;
            ring_top[s]    = 0;
            ring_fill[s]   = 0;
            slot_misses[s] = '0;
            r.enable_ok    = 1'b1;
          end
        end
      end
      KIND_DISABLE: begin
        if (s >= 0) begin
          slot_on[s] = 1'b0;
          s = -1;
        end
      end
      KIND_PUSH: begin
        if (s >= 0) begin
          ring_mem[s * DEPTH + ring_top[s]] = c.return_addr;
          ring_top[s] = (ring_top[s] + 1) % DEPTH;
          if (ring_fill[s] < DEPTH) ring_fill[s]++;
        end
      end
      KIND_CHECK: begin
        if (s >= 0 && ring_fill[s] != 0) begin
          p = (ring_top[s] == 0) ? DEPTH - 1 : ring_top[s] - 1;
          popped = ring_mem[s * DEPTH + p];
          ring_top[s] = p;
          ring_fill[s]--;
          r.expected_addr = popped;
          if (popped != c.return_addr) begin
            if (slot_misses[s] != 32'hFFFF_FFFF) slot_misses[s]++;
            r.rop_detected      = 1'b1;
            r.alert_rip         = c.rip;
            r.alert_key         = c.cr3;
            r.alert_actual_addr = c.return_addr;
          end
        end
      end
      default: ;
    endcase
    if (s >= 0) begin
      r.mismatch_total = slot_misses[s];
      r.stack_fill     = OUT_FILL_W'(ring_fill[s]);
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 10)
        $display("mismatch in %s at %0t: expected %h, got %h", name, $time, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      awaited.delete();
      for (int i = 0; i < PROCS; i++) begin
        slot_on[i]     = 1'b0;
        ring_top[i]    = 0;
        ring_fill[i]   = 0;
        slot_misses[i] = '0;
      end
    end else begin
      // the result on this edge always belongs to an earlier transfer
      if (done) begin
        if (awaited.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("result at %0t with no command outstanding: %h", $time, result);
        end else begin
          oldest = awaited.pop_front();
          compared++;
          check_field("monitored", 64'(oldest.monitored), 64'(result.monitored));
          check_field("enable_ok", 64'(oldest.enable_ok), 64'(result.enable_ok));
          check_field("rop_detected", 64'(oldest.rop_detected), 64'(result.rop_detected));
          check_field("expected_addr", oldest.expected_addr, result.expected_addr);
          check_field("alert_rip", oldest.alert_rip, result.alert_rip);
          check_field("alert_key", oldest.alert_key, result.alert_key);
          check_field("alert_actual_addr", oldest.alert_actual_addr,
                      result.alert_actual_addr);
          check_field("mismatch_total", 64'(oldest.mismatch_total),
                      64'(result.mismatch_total));
          check_field("stack_fill", 64'(oldest.stack_fill), 64'(result.stack_fill));
        end
      end
      if (start && !busy) begin
        fresh = shadow_step(cmd);
        if (fresh.rop_detected) detections++;
        if (cmd.kind == KIND_ENABLE && !fresh.enable_ok) refused++;
        awaited.push_back(fresh);
      end
    end
    pending = awaited.size();
  end

endmodule

>>> verif/per_process_shadow_return_stack_top_tb.sv
`timescale 1ns / 1ps
// top of the shadow return stack testbench: clock, reset, command stimulus and verdict
module per_process_shadow_return_stack_top_tb;
  import pps_pkg::*;

  localparam int KEYS = 10;  // two more keys than slots, so the table fills up

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  cmd_t cmd = '0;
  res_t result;

  int errors;
  int pending;
  int compared;
  int detections;
  int refused;

  // stimulus-side view of which pool keys hold a slot and what they pushed;
  // only used to shape calls and returns, never to predict results
  logic [63:0] key_pool [KEYS];
  bit          key_on   [KEYS];
  int          on_count;
  logic [63:0] pushed   [KEYS][$];

  int idle_pct;   // chance in a hundred of one more idle cycle before a transfer
  int sent;       // transfers accepted so far

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  per_process_shadow_return_stack_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  pps_return_checker i_return_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .done       (done),
    .result     (result),
    .errors     (errors),
    .pending    (pending),
    .compared   (compared),
    .detections (detections),
    .refused    (refused)
  );

  // random 64-bit value, with the all-zero and all-one extremes now and then
  function automatic logic [63:0] rand64();
    int pick;
    pick = $urandom_range(15);
    if (pick == 0) return 64'h0;
    if (pick == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // one command transfer: optional idle gap, then hold start until busy is low
  // at an edge; start is either kept high or dropped by the next call, never both
  task automatic send(kind_t k, logic [63:0] key, logic [63:0] addr, logic [63:0] ip);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= '{kind: k, cr3: key, return_addr: addr, rip: ip};
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic op_enable(int k);
    if (!key_on[k] && on_count < PROCS) begin
      key_on[k] = 1'b1;
      on_count++;
      pushed[k].delete();
    end
    send(KIND_ENABLE, key_pool[k], rand64(), rand64());
  endtask

  task automatic op_disable(int k);
    if (key_on[k]) begin
      key_on[k] = 1'b0;
      on_count--;
      pushed[k].delete();
    end
    send(KIND_DISABLE, key_pool[k], rand64(), rand64());
  endtask

  task automatic op_push(int k, logic [63:0] addr);
    if (key_on[k]) begin
      pushed[k].push_back(addr);
      // ring overwrites its oldest entry once full
      if (pushed[k].size() > DEPTH) void'(pushed[k].pop_front());
    end
    send(KIND_PUSH, key_pool[k], addr, rand64());
  endtask

  // a return: honest ones hand back the address that was called, others corrupt it
  task automatic op_check(int k, bit honest);
    logic [63:0] addr;
    logic [63:0] called;
    addr = rand64();
    if (key_on[k] && pushed[k].size() > 0) begin
      called = pushed[k].pop_back();
      if (honest) addr = called;
    end
    send(KIND_CHECK, key_pool[k], addr, rand64());
  endtask

  // random traffic, mostly call/return chains on pool keys
  task automatic run_phase(int pct, int count, bit with_burst);
    int stop_at;
    int k;
    int n;
    int pick;
    idle_pct = pct;
    if (with_burst) begin
      // wrap one ring past full, then pop back across the wrap point
      if (!key_on[2]) op_enable(2);
      repeat (DEPTH + 14) op_push(2, rand64());
      repeat (20) op_check(2, $urandom_range(99) < 90);
    end
    stop_at = sent + count;
    while (sent < stop_at) begin
      pick = $urandom_range(99);
      k    = $urandom_range(KEYS - 1);
      if (pick < 60) begin
        // nested calls then their returns
        if (!key_on[k]) op_enable(k);
        n = $urandom_range(8, 1);
        repeat (n) op_push(k, rand64());
        repeat (n) op_check(k, $urandom_range(99) < 90);
      end else if (pick < 70) begin
        op_enable(k);
      end else if (pick < 80) begin
        op_disable(k);
      end else if (pick < 86) begin
        op_push(k, rand64());
      end else if (pick < 92) begin
        op_check(k, 1'($urandom_range(1)));
      end else begin
        // any kind on a key that is almost surely unknown
        send(kind_t'($urandom_range(3)), rand64(), rand64(), rand64());
      end
    end
  endtask

  initial begin
    int waited;
    key_pool[0] = 64'h0;
    key_pool[1] = '1;
    for (int i = 2; i < KEYS; i++) key_pool[i] = {$urandom, $urandom} | 64'h1000;
    on_count = 0;
    idle_pct = 0;
    sent     = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: unknown key, empty stack, extremes, already active, full table
    op_check(0, 1'b1);            // return on a key that is not monitored
    op_push(0, rand64());         // call on a key that is not monitored
    op_disable(0);                // disable of an unknown key
    op_enable(0);                 // all-zero key
    op_check(0, 1'b1);            // return with nothing on the stack
    op_enable(0);                 // enable of a key already active
    op_push(0, 64'h0);
    op_push(0, '1);
    op_check(0, 1'b1);            // clean return of the all-one address
    op_check(0, 1'b0);            // corrupted return of the zero address
    op_enable(1);                 // all-one key
    for (int i = 2; i < PROCS; i++) op_enable(i);
    op_enable(PROCS);             // every slot taken, refused
    op_disable(3);
    op_enable(PROCS);             // takes the slot just freed
    op_push(1, rand64());
    op_check(1, 1'b0);

    // pacing phases: none, heavy idling, light idling
    run_phase(0, 200, 1'b1);
    run_phase(82, 200, 1'b0);
    run_phase(10, 200, 1'b0);

    start <= 1'b0;

    // let the last results drain, then a few cycles for stray strobes
    waited = 0;
    while (pending != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);

    $display("%0d commands transferred in three pacing phases, %0d results compared",
             sent, compared);
    $display("%0d return mismatches flagged, %0d enables refused on a full table",
             detections, refused);
    if (pending != 0) $display("%0d results never arrived", pending);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
